@@ rtl/a2a_pkg.sv @@
package a2a_pkg;

   // field widths
   localparam int PE_W   = 6;
   localparam int CNT_W  = 7;
   localparam int STEP_W = 6;

   // configuration port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // register index taken from paddr[2]
   localparam logic CSR_NUM_PES = 1'b0;

   localparam logic [CNT_W-1:0] NUM_PES_RESET = 7'd1;

   // node count limit: node ceiling and results per request
   localparam int MAX_PES      = 64;
   localparam int RESULT_LIMIT = 64;
   localparam int CNT_LIMIT    = (MAX_PES < RESULT_LIMIT) ? MAX_PES : RESULT_LIMIT;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // one classified request
   typedef struct packed {
      logic [PE_W-1:0]  pe_index;
      logic [CNT_W-1:0] count;
      logic             bad;
   } job_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

@@ rtl/a2a_front.sv @@
module a2a_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [a2a_pkg::PE_W-1:0]  req_pe_index,
   input  logic [a2a_pkg::CNT_W-1:0] num_pes,
   input  logic                      q_full,
   output logic                      q_push,
   output a2a_pkg::job_type          q_job
);
   import a2a_pkg::*;

   logic [CNT_W-1:0] count;

   // saturate the node count to the supported limit
   assign count = (num_pes > CNT_W'(CNT_LIMIT)) ? CNT_W'(CNT_LIMIT) : num_pes;

   // classify: an index not below the count is a bad request
   always_comb begin
      q_job.pe_index = req_pe_index;
      q_job.count    = count;
      q_job.bad      = ({1'b0, req_pe_index} >= count);
   end

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

endmodule

@@ rtl/a2a_queue.sv @@
module a2a_queue #(
   parameter int DEPTH = a2a_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  a2a_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output a2a_pkg::job_type pop_job,
   output logic             empty
);
   import a2a_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full    = (fill_ff == FILL_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/a2a_back.sv @@
module a2a_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  a2a_pkg::job_type           q_job,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [a2a_pkg::PE_W-1:0]   rsp_partner,
   output logic [a2a_pkg::STEP_W-1:0] rsp_step,
   output logic                       rsp_last,
   output logic                       rsp_bad_request
);
   import a2a_pkg::*;

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic [PE_W-1:0]    round_ff, round_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PE_W-1:0]    partner_ff, partner_in;
   logic [STEP_W-1:0]  rsp_step_ff, rsp_step_in;
   logic               last_ff, last_in;
   logic               bad_ff, bad_in;

   logic               even;
   logic [CNT_W-1:0]   modulus;
   logic [CNT_W-1:0]   cnt_m1;
   logic [CNT_W:0]     t0, t1, t2;
   logic [PE_W-1:0]    round_partner;
   logic               out_free;
   logic               self_slot;
   logic               is_last;

   assign even     = ~job_ff.count[0];
   assign cnt_m1   = job_ff.count - 1'b1;
   assign modulus  = even ? cnt_m1 : job_ff.count;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign self_slot = even && (step_ff == '0);
   assign is_last  = ({1'b0, step_ff} == cnt_m1);

   // rotation partner (2*round - index) mod m, index never above m
   always_comb begin
      t0 = {1'b0, round_ff, 1'b0} + {1'b0, modulus} - {2'b0, job_ff.pe_index};
      t1 = (t0 >= {1'b0, modulus}) ? t0 - {1'b0, modulus} : t0;
      t2 = (t1 >= {1'b0, modulus}) ? t1 - {1'b0, modulus} : t1;
      if (round_ff == job_ff.pe_index) begin
         round_partner = even ? cnt_m1[PE_W-1:0] : job_ff.pe_index;
      end else if (even && ({1'b0, job_ff.pe_index} == cnt_m1)) begin
         round_partner = round_ff;
      end else begin
         round_partner = t2[PE_W-1:0];
      end
   end

   // sequencer: one result per cycle while the output register has room
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      round_in     = round_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      partner_in   = partner_ff;
      rsp_step_in  = rsp_step_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               round_in = '0;
               step_in  = '0;
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_step_in  = step_ff;
               if (job_ff.bad) begin
                  partner_in = '0;
                  last_in    = 1'b1;
                  bad_in     = 1'b1;
                  state_in   = BACK_IDLE;
               end else begin
                  bad_in     = 1'b0;
                  last_in    = is_last;
                  partner_in = self_slot ? job_ff.pe_index : round_partner;
                  if (!self_slot) begin
                     round_in = round_ff + 1'b1;
                  end
                  step_in = step_ff + 1'b1;
                  if (is_last) begin
                     state_in = BACK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and job registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      round_ff    <= round_in;
      step_ff     <= step_in;
      partner_ff  <= partner_in;
      rsp_step_ff <= rsp_step_in;
      last_ff     <= last_in;
      bad_ff      <= bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_partner     = partner_ff;
   assign rsp_step        = rsp_step_ff;
   assign rsp_last        = last_ff;
   assign rsp_bad_request = bad_ff;

endmodule

@@ rtl/all_to_all_partner_schedule.sv @@
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_pe_index
// rsp       out        rsp_valid/rsp_stall  rsp_partner, rsp_step, rsp_last, rsp_bad_request
// csr       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata (num_pes)
//
// A request yields one result per node (num_pes, capped at 64; one for a bad request),
// one per cycle from the back sequencer while the output register has room; the sequencer
// takes the next request from the queue only after the last result of the current one.
// Reset is synchronous; num_pes comes back as 1 and the queue and output are emptied.
// A stall on rsp holds the output register; the front keeps taking requests
// until the queue is full, then raises req_stall.
module all_to_all_partner_schedule #(
   parameter int QUEUE_DEPTH = a2a_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [a2a_pkg::PE_W-1:0]    req_pe_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [a2a_pkg::PE_W-1:0]    rsp_partner,
   output logic [a2a_pkg::STEP_W-1:0]  rsp_step,
   output logic                        rsp_last,
   output logic                        rsp_bad_request,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [a2a_pkg::ADDR_W-1:0]  paddr,
   input  logic [a2a_pkg::DATA_W-1:0]  pwdata,
   output logic [a2a_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import a2a_pkg::*;

   logic [CNT_W-1:0] num_pes_ff, num_pes_in;
   logic             csr_write;
   logic             q_push, q_full, q_pop, q_empty;
   job_type          push_job, pop_job;

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      num_pes_in = num_pes_ff;
      if (csr_write && (paddr[2] == CSR_NUM_PES)) begin
         num_pes_in = pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_NUM_PES) begin
         prdata = {{(DATA_W - CNT_W){1'b0}}, num_pes_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_pes_ff <= NUM_PES_RESET;
      end else begin
         num_pes_ff <= num_pes_in;
      end
   end

   a2a_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pe_index (req_pe_index),
      .num_pes      (num_pes_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (push_job)
   );

   a2a_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   a2a_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_job           (pop_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_partner     (rsp_partner),
      .rsp_step        (rsp_step),
      .rsp_last        (rsp_last),
      .rsp_bad_request (rsp_bad_request)
   );

endmodule
